[hw/rtl/mep_pkg.sv]
// ----------------------------------------------------------------------------
// mep_pkg: shared types and constants for the escape-time pixel engine
// Register layout, fixed field widths, state encodings and the sizes of the
// coordinate mapping datapath.
// ----------------------------------------------------------------------------
package mep_pkg;

  // Fixed field and register widths.
  localparam int COORD_BITS   = 12;
  localparam int ITER_W       = 10;
  localparam int GRAY_W       = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int HALF_W       = 31;

  // Mapping datapath widths.
  // hh = hw*h/w stays below 2^43, 2*hw*px below 2^44, 2*hh*py below 2^56.
  localparam int MUL_A_W      = 43;
  localparam int MUL_B_W      = COORD_BITS;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int DIV_W        = PROD_W + 1;
  localparam int DIV_CNT_W    = $clog2(DIV_W);
  localparam int HH_W         = 43;
  localparam int QX_W         = 44;
  localparam int MAP_W        = DIV_W + 2;

  localparam logic [GRAY_W-1:0] GRAY_MAX = 2'd3;
  localparam logic [GRAY_W-1:0] GRAY_MID = 2'd2;
  localparam logic [GRAY_W-1:0] GRAY_LOW = 2'd1;
  localparam logic [GRAY_W-1:0] GRAY_MIN = 2'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_RE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd5;

  // Reset values.
  localparam logic [31:0]         RST_CENTER_RE  = 32'd0;
  localparam logic [31:0]         RST_CENTER_IM  = 32'd0;
  localparam logic [HALF_W-1:0]   RST_HALF_WIDTH = 31'd429496730;
  localparam logic [ITER_W-1:0]   RST_ITER_LIMIT = 10'd256;
  localparam logic [COORD_BITS-1:0] RST_IMG_WIDTH  = 12'd960;
  localparam logic [COORD_BITS-1:0] RST_IMG_HEIGHT = 12'd540;

  typedef struct packed {
    logic [31:0]             center_re;
    logic [31:0]             center_im;
    logic [HALF_W-1:0]       half_width;
    logic [ITER_W-1:0]       iteration_limit;
    logic [COORD_BITS-1:0]   image_width;
    logic [COORD_BITS-1:0]   image_height;
  } cfg_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV_HH,
    F_DIV_QX,
    F_DIV_QY,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

endpackage

[hw/rtl/mandelbrot_escape_pixel.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel: escape-time evaluator for one pixel per transfer
//
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  pixel_x, pixel_y
// m_*      out  m_tvalid/m_tready  gray_level, iteration_count
// cfg_*    in   cfg_we             register index and write data
//
// The mapping stage makes three passes of the bit-serial divider per pixel
// (one quotient bit per cycle over 56 bits).
// The escape loop runs one iteration per cycle.
// Both stages overlap through a small queue; the slower one sets the rate.
// Reset is synchronous and active high; it restores the register defaults.
// A stalled output holds its result while the next pixels are still mapped.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel #(
  parameter int FRAC_BITS   = 28,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,   // pixel_x[11:0], pixel_y[23:12]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // gray_level[1:0], iteration_count[11:2]
  input  logic                            cfg_we,
  input  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int VAL_BITS = FRAC_BITS + 4;
  localparam int ITEM_W   = 2 * VAL_BITS;

  mep_pkg::cfg_t               cfg;

  logic                        q_push;
  logic                        q_full;
  logic [ITEM_W-1:0]           q_in;
  logic                        q_pop;
  logic                        q_valid;
  logic [ITEM_W-1:0]           q_out;
  logic [mep_pkg::GRAY_W-1:0]  out_gray;
  logic [mep_pkg::ITER_W-1:0]  out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_re       <= mep_pkg::RST_CENTER_RE;
      cfg.center_im       <= mep_pkg::RST_CENTER_IM;
      cfg.half_width      <= mep_pkg::RST_HALF_WIDTH;
      cfg.iteration_limit <= mep_pkg::RST_ITER_LIMIT;
      cfg.image_width     <= mep_pkg::RST_IMG_WIDTH;
      cfg.image_height    <= mep_pkg::RST_IMG_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        mep_pkg::CFG_CENTER_RE:  cfg.center_re       <= cfg_data;
        mep_pkg::CFG_CENTER_IM:  cfg.center_im       <= cfg_data;
        mep_pkg::CFG_HALF_WIDTH: cfg.half_width      <= cfg_data[mep_pkg::HALF_W-1:0];
        mep_pkg::CFG_ITER_LIMIT: cfg.iteration_limit <= cfg_data[mep_pkg::ITER_W-1:0];
        mep_pkg::CFG_IMG_WIDTH:  cfg.image_width     <= cfg_data[mep_pkg::COORD_BITS-1:0];
        mep_pkg::CFG_IMG_HEIGHT: cfg.image_height    <= cfg_data[mep_pkg::COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  mep_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .pixel_x  (s_tdata[11:0]),
    .pixel_y  (s_tdata[23:12]),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (q_in)
  );

  mep_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_out)
  );

  mep_escape #(
    .FRAC_BITS (FRAC_BITS)
  ) u_escape (
    .clk       (clk),
    .rst       (rst),
    .limit     (cfg.iteration_limit),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_gray  (out_gray),
    .out_count (out_count)
  );

  assign m_tdata = {4'b0000, out_count, out_gray};

`ifndef NO_ASSERTIONS
  a_count_within_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_count <= cfg.iteration_limit))
    else $error("iteration count above the configured limit");

  a_gray_max_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((out_gray == mep_pkg::GRAY_MAX) == (out_count == cfg.iteration_limit)))
    else $error("top shade does not match a pixel that reached the limit");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("mapping stage pushed into a full queue");

  a_one_pixel_in_front: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("mapping stage took a second pixel while busy");
`endif

endmodule

[hw/rtl/mep_divider.sv]
// ----------------------------------------------------------------------------
// mep_divider: restoring unsigned divider, one quotient bit per cycle
// Divides a DIV_W-bit dividend by a pixel-count divisor. The result is
// flagged by a one-cycle done pulse and holds until the next start.
// ----------------------------------------------------------------------------
module mep_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mep_pkg::DIV_W-1:0]      dividend,
  input  logic [mep_pkg::COORD_BITS-1:0] divisor,
  output logic                           done,
  output logic [mep_pkg::DIV_W-1:0]      quotient
);

  localparam int DW = mep_pkg::DIV_W;
  localparam int RW = mep_pkg::COORD_BITS;

  logic [DW-1:0]                  quo;
  logic [RW-1:0]                  rem;
  logic [RW-1:0]                  dvs;
  logic [mep_pkg::DIV_CNT_W-1:0]  cnt;
  logic                           active;
  logic [RW:0]                    trial;
  logic [RW:0]                    diff;
  logic                           fits;

  assign trial = {rem, quo[DW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == mep_pkg::DIV_CNT_W'(DW - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (active) begin
      rem <= fits ? diff[RW-1:0] : trial[RW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

[hw/rtl/mep_fifo.sv]
// ----------------------------------------------------------------------------
// mep_fifo: small register queue between the mapping and iteration stages
// First-word-fall-through queue; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module mep_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

[hw/rtl/mep_front.sv]
// ----------------------------------------------------------------------------
// mep_front: pixel to complex-plane mapping
// Accepts a pixel, forms the half height and both scaled offsets with one
// shared multiplier and the serial divider, then queues the point c.
// ----------------------------------------------------------------------------
module mep_front #(
  parameter int FRAC_BITS = 28
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mep_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mep_pkg::COORD_BITS-1:0]  pixel_x,
  input  logic [mep_pkg::COORD_BITS-1:0]  pixel_y,
  output logic                            q_push,
  input  logic                            q_full,
  output logic [2*(FRAC_BITS+4)-1:0]      q_data
);

  localparam int VAL_BITS = FRAC_BITS + 4;
  localparam int MAP_W    = mep_pkg::MAP_W;

  mep_pkg::front_state_t state, state_next;

  logic [mep_pkg::COORD_BITS-1:0] px, py, wd, ht;
  logic [mep_pkg::HH_W-1:0]       hh;
  logic [mep_pkg::QX_W-1:0]       qx;
  logic signed [VAL_BITS-1:0]     cx, cy;
  logic                           launched;

  logic                           div_start;
  logic                           div_done;
  logic [mep_pkg::DIV_W-1:0]      div_dividend;
  logic [mep_pkg::COORD_BITS-1:0] div_divisor;
  logic [mep_pkg::DIV_W-1:0]      div_quotient;

  logic [mep_pkg::MUL_A_W-1:0]    mul_a;
  logic [mep_pkg::MUL_B_W-1:0]    mul_b;
  logic [mep_pkg::PROD_W-1:0]     prod;

  logic signed [MAP_W-1:0]        map_x, map_y;

  function automatic logic signed [VAL_BITS-1:0] sat_val(input logic signed [MAP_W-1:0] v);
    logic fits;
    fits = (v[MAP_W-1:VAL_BITS-1] == {(MAP_W-VAL_BITS+1){v[MAP_W-1]}});
    if (fits) begin
      sat_val = v[VAL_BITS-1:0];
    end else begin
      sat_val = {v[MAP_W-1], {(VAL_BITS-1){!v[MAP_W-1]}}};
    end
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a        = mep_pkg::MUL_A_W'(cfg.half_width);
    mul_b        = ht;
    div_divisor  = wd;
    div_dividend = mep_pkg::DIV_W'(prod);
    case (state)
      mep_pkg::F_DIV_QX: begin
        mul_b        = px;
        div_dividend = {prod, 1'b0};
      end
      mep_pkg::F_DIV_QY: begin
        mul_a        = hh;
        mul_b        = py;
        div_divisor  = ht;
        div_dividend = {prod, 1'b0};
      end
      default: begin
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign map_x = MAP_W'($signed(cfg.center_re))
               - $signed(MAP_W'(cfg.half_width))
               + $signed(MAP_W'(qx));
  assign map_y = MAP_W'($signed(cfg.center_im))
               - $signed(MAP_W'(hh))
               + $signed(MAP_W'(div_quotient));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mep_pkg::F_IDLE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      if (div_done) begin
        launched <= 1'b0;
      end else if (div_start) begin
        launched <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    q_push     = 1'b0;
    case (state)
      mep_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = mep_pkg::F_DIV_HH;
        end
      end
      mep_pkg::F_DIV_HH: begin
        div_start = !launched;
        if (div_done) begin
          state_next = mep_pkg::F_DIV_QX;
        end
      end
      mep_pkg::F_DIV_QX: begin
        div_start = !launched;
        if (div_done) begin
          state_next = mep_pkg::F_DIV_QY;
        end
      end
      mep_pkg::F_DIV_QY: begin
        div_start = !launched;
        if (div_done) begin
          state_next = mep_pkg::F_PUSH;
        end
      end
      mep_pkg::F_PUSH: begin
        q_push = !q_full;
        if (!q_full) begin
          state_next = mep_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = mep_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == mep_pkg::F_IDLE && in_valid) begin
      px <= pixel_x;
      py <= pixel_y;
      // A zero image size counts as one pixel.
      wd <= (cfg.image_width == '0) ? mep_pkg::COORD_BITS'(1) : cfg.image_width;
      ht <= (cfg.image_height == '0) ? mep_pkg::COORD_BITS'(1) : cfg.image_height;
    end
    if (div_done) begin
      case (state)
        mep_pkg::F_DIV_HH: hh <= div_quotient[mep_pkg::HH_W-1:0];
        mep_pkg::F_DIV_QX: qx <= div_quotient[mep_pkg::QX_W-1:0];
        mep_pkg::F_DIV_QY: begin
          cx <= sat_val(map_x);
          cy <= sat_val(map_y);
        end
        default: begin
        end
      endcase
    end
  end

  assign q_data = {cy, cx};

  mep_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

[hw/rtl/mep_escape.sv]
// ----------------------------------------------------------------------------
// mep_escape: escape-time iteration of z = z*z + c
// One iteration per cycle from the z registers through three multipliers
// and the saturating adders back into z; the result sits in an output
// register until it is taken.
// ----------------------------------------------------------------------------
module mep_escape #(
  parameter int FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mep_pkg::ITER_W-1:0]    limit,
  input  logic                          q_valid,
  input  logic [2*(FRAC_BITS+4)-1:0]    q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mep_pkg::GRAY_W-1:0]    out_gray,
  output logic [mep_pkg::ITER_W-1:0]    out_count
);

  localparam int VAL_BITS = FRAC_BITS + 4;
  localparam int SQ_W     = 2 * VAL_BITS - FRAC_BITS;
  localparam int SUM_W    = SQ_W + 2;
  localparam logic signed [SUM_W-1:0] FOUR = $signed(SUM_W'(1) << (FRAC_BITS + 2));

  mep_pkg::back_state_t state, state_next;

  logic signed [VAL_BITS-1:0]   zx, zy, cx, cy;
  logic [mep_pkg::ITER_W-1:0]   iter;

  logic signed [2*VAL_BITS-1:0] pxx, pyy, pxy;
  logic signed [SQ_W-1:0]       sx, sy;
  logic signed [SQ_W:0]         sxy2;
  logic signed [SUM_W-1:0]      mag, nx_raw, ny_raw;
  logic                         escaped;
  logic                         finish;
  logic                         out_free;
  logic                         out_load;
  logic [mep_pkg::ITER_W+1:0]   tri_iter;
  logic [mep_pkg::ITER_W:0]     two_limit;
  logic [mep_pkg::GRAY_W-1:0]   gray;

  function automatic logic signed [VAL_BITS-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:VAL_BITS-1] == {(SUM_W-VAL_BITS+1){v[SUM_W-1]}});
    if (fits) begin
      sat_val = v[VAL_BITS-1:0];
    end else begin
      sat_val = {v[SUM_W-1], {(VAL_BITS-1){!v[SUM_W-1]}}};
    end
  endfunction

  assign pxx = zx * zx;
  assign pyy = zy * zy;
  assign pxy = zx * zy;

  // Products truncate toward minus infinity; 2*zx*zy keeps one more bit.
  assign sx   = pxx[2*VAL_BITS-1:FRAC_BITS];
  assign sy   = pyy[2*VAL_BITS-1:FRAC_BITS];
  assign sxy2 = pxy[2*VAL_BITS-1:FRAC_BITS-1];

  assign mag    = SUM_W'(sx) + SUM_W'(sy);
  assign nx_raw = SUM_W'(sx) - SUM_W'(sy) + SUM_W'(cx);
  assign ny_raw = SUM_W'(sxy2) + SUM_W'(cy);

  assign escaped  = (mag >= FOUR);
  assign finish   = (iter == limit) || escaped;
  assign out_free = !out_valid || out_ready;

  // iter*3/limit is below three once iter < limit, so two compares suffice.
  assign tri_iter  = {1'b0, iter, 1'b0} + (mep_pkg::ITER_W+2)'(iter);
  assign two_limit = {limit, 1'b0};

  always_comb begin
    if (iter == limit) begin
      gray = mep_pkg::GRAY_MAX;
    end else if (tri_iter >= (mep_pkg::ITER_W+2)'(two_limit)) begin
      gray = mep_pkg::GRAY_MID;
    end else if (tri_iter >= (mep_pkg::ITER_W+2)'(limit)) begin
      gray = mep_pkg::GRAY_LOW;
    end else begin
      gray = mep_pkg::GRAY_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mep_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    case (state)
      mep_pkg::B_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          state_next = mep_pkg::B_RUN;
        end
      end
      mep_pkg::B_RUN: begin
        if (finish && out_free) begin
          out_load   = 1'b1;
          state_next = mep_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = mep_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx   <= q_data[VAL_BITS-1:0];
      cy   <= q_data[2*VAL_BITS-1:VAL_BITS];
      zx   <= '0;
      zy   <= '0;
      iter <= '0;
    end else if (state == mep_pkg::B_RUN && !finish) begin
      zx   <= sat_val(nx_raw);
      zy   <= sat_val(ny_raw);
      iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_gray  <= gray;
      out_count <= iter;
    end
  end

endmodule
